// ===== design/rtn_pkg.sv =====
// Shared constants, types and helpers for the ray/triangle nearest-hit block.
// Used by every module of the block; has no dependencies.
package rtn_pkg;

	localparam int COORD_W   = 20;
	localparam int NORM_W    = 16;
	localparam int DIST_W    = 24;
	localparam int DIST_FRAC = 10;

	// Exact intermediate widths (signed unless noted).
	localparam int DIFF_W  = COORD_W + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int DOT_W   = 3 * DIFF_W + 1;
	localparam int W0_W    = DOT_W + 2;
	localparam int DEN_W   = DOT_W - 1;
	localparam int NUM_R_W = DOT_W - 1 + DIST_FRAC;
	localparam int NUM_N_W = DOT_W + NORM_W - 2;
	localparam int NUM_W   = (NUM_R_W > NUM_N_W) ? NUM_R_W : NUM_N_W;
	localparam int QW      = ((DIST_W > NORM_W) ? DIST_W : NORM_W) + 1;
	localparam int NUM_CW  = $clog2(NUM_W);

	// Multiplier: one chunk of the wide operand times a narrow operand per cycle.
	localparam int CH_W    = 23;
	localparam int NCH     = (W0_W + CH_W - 1) / CH_W;
	localparam int NCH_CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int WIDE_W  = NCH * CH_W;
	localparam int NAR_W   = (DIFF_W > NORM_W) ? DIFF_W : NORM_W;
	localparam int PROD_W  = CH_W + 1 + NAR_W;
	localparam int ACC_W   = NUM_W + 2;

	// Stream and configuration widths.
	localparam int VTX_W       = 3 * COORD_W;
	localparam int NRM_W       = 3 * NORM_W;
	localparam int IN_BITS     = 3 * VTX_W + 3 * NRM_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = DIST_W + 3 * NORM_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_W       = (COORD_W > DIST_W) ? COORD_W : DIST_W;
	localparam int IDX_W       = 3;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);

	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_DIST = 3'd6;

	// Cross product groups and dot product slots.
	localparam logic [1:0] GRP_N  = 2'd0;
	localparam logic [1:0] GRP_EV = 2'd1;
	localparam logic [1:0] GRP_UE = 2'd2;
	localparam logic [1:0] DOT_D  = 2'd0;
	localparam logic [1:0] DOT_R  = 2'd1;
	localparam logic [1:0] DOT_S  = 2'd2;
	localparam logic [1:0] DOT_T  = 2'd3;

	// One triangle after the front end: edge vectors and vertex normals.
	typedef struct packed {
		logic                             first;
		logic                             last;
		logic [2:0][DIFF_W-1:0]           u;
		logic [2:0][DIFF_W-1:0]           v;
		logic [2:0][DIFF_W-1:0]           e;
		logic [2:0][2:0][NORM_W-1:0]      nrm;
	} tri_item_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QW-1:0]    quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [DIFF_W-1:0] diff_of(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return DIFF_W'($signed(a)) - DIFF_W'($signed(b));
	endfunction

endpackage

// ===== design/rtn_front.sv =====
// Front end: takes triangle beats, forms edge vectors against the ray origin.
// Depends on rtn_pkg; feeds the triangle queue.
module rtn_front import rtn_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// vertex_a, vertex_b, vertex_c, normal_a, normal_b, normal_c, zero pad
	input  logic [IN_TDATA_W-1:0]      s_tdata,
	input  logic                       s_tuser,   // first_of_ray
	input  logic                       s_tlast,   // last_of_ray
	input  logic [2:0][COORD_W-1:0]    origin,
	output logic                       push_valid,
	input  logic                       push_ready,
	output tri_item_t                  push_data
);

	logic                        vld_s1;
	logic                        first_s1;
	logic                        last_s1;
	logic [2:0][2:0][COORD_W-1:0] vtx_s1;
	logic [2:0][2:0][NORM_W-1:0]  nrm_s1;

	assign s_tready = !vld_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					vtx_s1[k][i] <= s_tdata[k*VTX_W + i*COORD_W +: COORD_W];
					nrm_s1[k][i] <= s_tdata[3*VTX_W + k*NRM_W + i*NORM_W +: NORM_W];
				end
			end
		end
	end

	always_comb begin
		push_data.first = first_s1;
		push_data.last  = last_s1;
		push_data.nrm   = nrm_s1;
		for (int i = 0; i < 3; i++) begin
			push_data.u[i] = diff_of(vtx_s1[1][i], vtx_s1[0][i]);
			push_data.v[i] = diff_of(vtx_s1[2][i], vtx_s1[0][i]);
			push_data.e[i] = diff_of(origin[i], vtx_s1[0][i]);
		end
	end

	assign push_valid = vld_s1;

endmodule

// ===== design/rtn_fifo.sv =====
// Short triangle queue between the front end and the back end.
// Depends on rtn_pkg for the item type and depth.
module rtn_fifo import rtn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  tri_item_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output tri_item_t pop_data
);

	tri_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_PTR_W:0]     cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (cnt_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== design/rtn_div.sv =====
// Shared restoring divider, one quotient bit per cycle over the full numerator.
// Depends on rtn_pkg; keeps the low quotient bits and flags any higher one.
module rtn_div import rtn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [NUM_CW-1:0]   cnt_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [QW-1:0]       quo_q;
	logic                ovf_q;
	logic [DEN_W+1:0]    trial;
	logic                ge;

	assign trial = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
	assign ge    = !trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NUM_CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= cmd.num;
			den_q <= cmd.den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], num_q[NUM_W-1]};
			quo_q <= {quo_q[QW-2:0], ge};
			ovf_q <= ovf_q | quo_q[QW-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== design/rtn_back.sv =====
// Back end: sequencer with one shared chunked multiplier-accumulator, the hit
// tests, the nearest-hit state and the result register. Depends on rtn_pkg; drives rtn_div through its ports.
module rtn_back import rtn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  tri_item_t                pop_data,
	input  logic [2:0][COORD_W-1:0]  dir,
	input  logic [DIST_W-1:0]        max_dist,
	output div_cmd_t                 div_cmd,
	input  div_rsp_t                 div_rsp,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// distance, normal_x, normal_y, normal_z, zero pad
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	output logic                     m_tuser    // hit
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_CROSS  = 13'b0000000000010,
		S_DOT    = 13'b0000000000100,
		S_DWAIT  = 13'b0000000001000,
		S_CHECK  = 13'b0000000010000,
		S_DIVR   = 13'b0000000100000,
		S_BLEND  = 13'b0000001000000,
		S_BWAIT  = 13'b0000010000000,
		S_DIVN   = 13'b0000100000000,
		S_COMMIT = 13'b0001000000000,
		S_FIN    = 13'b0010000000000,
		S_SPARE0 = 13'b0100000000000,
		S_SPARE1 = 13'b1000000000000
	} bk_state_t;

	bk_state_t                   st_q;
	tri_item_t                   item_q;
	logic [2:0][2:0][CROSS_W-1:0] crs_q;
	logic [3:0][DOT_W-1:0]       dot_q;
	logic [W0_W-1:0]             w0_q;
	logic [1:0]                  sel_q;
	logic [1:0]                  comp_q;
	logic [1:0]                  term_q;
	logic [NCH_CW-1:0]           chk_q;
	logic                        nneg_q;

	// multiplier stage
	logic signed [PROD_W-1:0]    prod_s1;
	logic                        pvld_s1;
	logic [NCH_CW-1:0]           psh_s1;
	logic                        psub_s1;
	logic                        pdone_s1;
	bk_state_t                   pst_s1;
	logic [1:0]                  psel_s1;
	logic [1:0]                  pcomp_s1;
	logic [ACC_W-1:0]            acc_q;

	logic [DIST_W-1:0]           best_dist_q;
	logic                        any_hit_q;
	logic [2:0][NORM_W-1:0]      best_nrm_q;
	logic [DIST_W-1:0]           dist_new_q;
	logic [2:0][NORM_W-1:0]      nrm_new_q;

	// issue side
	logic [WIDE_W-1:0]           wide;
	logic signed [NAR_W-1:0]     nar;
	logic                        sub;
	logic                        last_term;
	logic                        last_chk;
	logic                        issuing;
	logic [1:0]                  i1;
	logic [1:0]                  i2;
	logic [2:0][DIFF_W-1:0]      av;
	logic [2:0][DIFF_W-1:0]      bv;
	logic [CH_W-1:0]             chunk;
	logic signed [CH_W:0]        chunk_s;
	logic signed [PROD_W-1:0]    prod;

	// accumulate side
	logic [ACC_W-1:0]            addend;
	logic [ACC_W-1:0]            acc_sum;
	logic                        acc_done;

	// tests and rounding
	logic                        dneg;
	logic [DOT_W-1:0]            dp;
	logic [DOT_W-1:0]            rp;
	logic [DOT_W-1:0]            sp;
	logic [DOT_W-1:0]            tp;
	logic [W0_W-1:0]             w0c;
	logic                        plane_ok;
	logic                        bneg;
	logic [ACC_W-1:0]            bmag;
	logic                        round_up;
	logic [QW:0]                 qr;
	logic [QW:0]                 lim;
	logic [QW:0]                 mag;
	logic [NORM_W-1:0]           nres;
	logic                        dist_win;
	logic                        emit_beat;

	assign issuing  = (st_q == S_CROSS) || (st_q == S_DOT) || (st_q == S_BLEND);
	assign last_chk = (chk_q == NCH_CW'(NCH - 1));

	always_comb begin
		case (comp_q)
			2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
			2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
			default: begin i1 = 2'd0; i2 = 2'd1; end
		endcase
		av = (sel_q == GRP_EV) ? item_q.e : item_q.u;
		bv = (sel_q == GRP_UE) ? item_q.e : item_q.v;
		wide      = '0;
		nar       = '0;
		sub       = 1'b0;
		last_term = 1'b0;
		case (st_q)
			S_CROSS: begin
				last_term = (term_q == 2'd1);
				if (term_q == 2'd0) begin
					wide = WIDE_W'($signed(av[i1]));
					nar  = NAR_W'($signed(bv[i2]));
				end else begin
					wide = WIDE_W'($signed(av[i2]));
					nar  = NAR_W'($signed(bv[i1]));
					sub  = 1'b1;
				end
			end
			S_DOT: begin
				last_term = (term_q == 2'd2);
				case (sel_q)
					DOT_D: begin
						wide = WIDE_W'($signed(crs_q[GRP_N][term_q]));
						nar  = NAR_W'($signed(dir[term_q]));
					end
					DOT_R: begin
						wide = WIDE_W'($signed(crs_q[GRP_N][term_q]));
						nar  = NAR_W'($signed(item_q.e[term_q]));
						sub  = 1'b1;
					end
					DOT_S: begin
						wide = WIDE_W'($signed(crs_q[GRP_EV][term_q]));
						nar  = NAR_W'($signed(dir[term_q]));
					end
					default: begin
						wide = WIDE_W'($signed(crs_q[GRP_UE][term_q]));
						nar  = NAR_W'($signed(dir[term_q]));
					end
				endcase
			end
			S_BLEND: begin
				last_term = (term_q == 2'd2);
				nar = NAR_W'($signed(item_q.nrm[term_q][comp_q]));
				case (term_q)
					2'd0:    wide = WIDE_W'($signed(w0_q));
					2'd1:    wide = WIDE_W'($signed(dot_q[DOT_S]));
					default: wide = WIDE_W'($signed(dot_q[DOT_T]));
				endcase
			end
			default: begin
				wide = '0;
			end
		endcase
		// Lower chunks are unsigned, the top chunk carries the sign.
		chunk   = wide[chk_q*CH_W +: CH_W];
		chunk_s = last_chk ? $signed({wide[chk_q*CH_W + CH_W - 1], chunk})
		                   : $signed({1'b0, chunk});
		prod    = chunk_s * nar;
	end

	assign addend   = ACC_W'(prod_s1) << (psh_s1 * CH_W);
	assign acc_sum  = psub_s1 ? (acc_q - addend) : (acc_q + addend);
	assign acc_done = pvld_s1 && pdone_s1;

	always_comb begin
		dneg = dot_q[DOT_D][DOT_W-1];
		dp   = dneg ? -dot_q[DOT_D] : dot_q[DOT_D];
		rp   = dneg ? -dot_q[DOT_R] : dot_q[DOT_R];
		sp   = dneg ? -dot_q[DOT_S] : dot_q[DOT_S];
		tp   = dneg ? -dot_q[DOT_T] : dot_q[DOT_T];
		w0c  = W0_W'($signed(dp)) - W0_W'($signed(sp)) - W0_W'($signed(tp));
		plane_ok = (dot_q[DOT_D] != '0) && !rp[DOT_W-1] && (rp != '0) &&
		           !sp[DOT_W-1] && !tp[DOT_W-1] && !w0c[W0_W-1];
		bneg = acc_sum[ACC_W-1];
		bmag = bneg ? -acc_sum : acc_sum;

		div_cmd.start = ((st_q == S_CHECK) && plane_ok) || (st_q == S_BWAIT);
		if (st_q == S_CHECK) begin
			div_cmd.num = NUM_W'(rp[DOT_W-2:0]) << DIST_FRAC;
			div_cmd.den = dp[DEN_W-1:0];
		end else begin
			div_cmd.num = bmag[NUM_W-1:0];
			div_cmd.den = dot_q[DOT_D][DEN_W-1:0];
		end

		// Round half away from zero, then clamp to the signed normal range.
		round_up = ({div_rsp.rem, 1'b0} >= {1'b0, dot_q[DOT_D][DEN_W-1:0]});
		qr  = {1'b0, div_rsp.quo} + (QW+1)'(round_up);
		lim = nneg_q ? (QW+1)'(1) << (NORM_W - 1) : ((QW+1)'(1) << (NORM_W - 1)) - 1'b1;
		mag = (div_rsp.ovf || (qr > lim)) ? lim : qr;
		nres = nneg_q ? -mag[NORM_W-1:0] : mag[NORM_W-1:0];
		dist_win = !div_rsp.ovf && (div_rsp.quo < QW'(best_dist_q));
	end

	assign pop_ready = (st_q == S_IDLE);
	assign emit_beat = (st_q == S_FIN) && item_q.last && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			sel_q       <= '0;
			comp_q      <= '0;
			term_q      <= '0;
			chk_q       <= '0;
			pvld_s1     <= 1'b0;
			acc_q       <= '0;
			best_dist_q <= '1;
			any_hit_q   <= 1'b0;
			best_nrm_q  <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			pvld_s1 <= issuing;
			if (acc_done) begin
				acc_q <= '0;
			end else if (pvld_s1) begin
				acc_q <= acc_sum;
			end
			if (emit_beat) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (issuing) begin
				chk_q <= last_chk ? '0 : chk_q + 1'b1;
				if (last_chk) begin
					term_q <= last_term ? 2'd0 : term_q + 1'b1;
				end
			end
			case (st_q)
				S_IDLE: begin
					if (pop_valid) begin
						if (pop_data.first) begin
							best_dist_q <= (max_dist == '0) ? '1 : max_dist;
							any_hit_q   <= 1'b0;
							best_nrm_q  <= '0;
						end
						sel_q  <= GRP_N;
						comp_q <= '0;
						term_q <= '0;
						chk_q  <= '0;
						st_q   <= S_CROSS;
					end
				end
				S_CROSS: begin
					if (last_chk && last_term) begin
						comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 1'b1;
						if (comp_q == 2'd2) begin
							if (sel_q == GRP_UE) begin
								sel_q <= DOT_D;
								st_q  <= S_DOT;
							end else begin
								sel_q <= sel_q + 1'b1;
							end
						end
					end
				end
				S_DOT: begin
					if (last_chk && last_term) begin
						sel_q <= sel_q + 1'b1;
						if (sel_q == DOT_T) begin
							st_q <= S_DWAIT;
						end
					end
				end
				S_DWAIT: begin
					st_q <= S_CHECK;
				end
				S_CHECK: begin
					st_q <= plane_ok ? S_DIVR : S_FIN;
				end
				S_DIVR: begin
					if (div_rsp.done) begin
						comp_q <= '0;
						term_q <= '0;
						chk_q  <= '0;
						st_q   <= dist_win ? S_BLEND : S_FIN;
					end
				end
				S_BLEND: begin
					if (last_chk && last_term) begin
						st_q <= S_BWAIT;
					end
				end
				S_BWAIT: begin
					st_q <= S_DIVN;
				end
				S_DIVN: begin
					if (div_rsp.done) begin
						if (comp_q == 2'd2) begin
							st_q <= S_COMMIT;
						end else begin
							comp_q <= comp_q + 1'b1;
							st_q   <= S_BLEND;
						end
					end
				end
				S_COMMIT: begin
					best_dist_q <= dist_new_q;
					any_hit_q   <= 1'b1;
					best_nrm_q  <= nrm_new_q;
					st_q        <= S_FIN;
				end
				S_FIN: begin
					if (!item_q.last || emit_beat) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		psh_s1   <= chk_q;
		psub_s1  <= sub;
		pdone_s1 <= last_chk && last_term;
		pst_s1   <= st_q;
		psel_s1  <= sel_q;
		pcomp_s1 <= comp_q;
		if ((st_q == S_IDLE) && pop_valid) begin
			item_q <= pop_data;
		end
		if (acc_done && (pst_s1 == S_CROSS)) begin
			crs_q[psel_s1][pcomp_s1] <= acc_sum[CROSS_W-1:0];
		end
		if (acc_done && (pst_s1 == S_DOT)) begin
			dot_q[psel_s1] <= acc_sum[DOT_W-1:0];
		end
		if (st_q == S_CHECK) begin
			// Fold the sign of the denominator into all four dot products.
			dot_q[DOT_D] <= dp;
			dot_q[DOT_R] <= rp;
			dot_q[DOT_S] <= sp;
			dot_q[DOT_T] <= tp;
			w0_q         <= w0c;
		end
		if (st_q == S_BWAIT) begin
			nneg_q <= bneg;
		end
		if ((st_q == S_DIVR) && div_rsp.done) begin
			dist_new_q <= div_rsp.quo[DIST_W-1:0];
		end
		if ((st_q == S_DIVN) && div_rsp.done) begin
			nrm_new_q[comp_q] <= nres;
		end
		if (emit_beat) begin
			m_tdata <= OUT_TDATA_W'({best_nrm_q[2], best_nrm_q[1], best_nrm_q[0], best_dist_q});
			m_tuser <= any_hit_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_hit_clears_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(any_hit_q) |-> $past(pop_valid && pop_ready && pop_data.first))
		else $error("hit flag cleared outside a ray reload");

	a_dist_changes: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(best_dist_q) |-> $past((st_q == S_COMMIT) || ((st_q == S_IDLE) && pop_valid)))
		else $error("best distance changed outside reload or commit");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((st_q == S_DIVR) || (st_q == S_DIVN)))
		else $error("divider finished while not awaited");

	a_commit_only_after_win: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_COMMIT) |-> $past(st_q == S_DIVN))
		else $error("commit without a finished normal blend");
`endif

endmodule

// ===== design/ray_triangle_nearest_hit_top.sv =====
// Top level of the ray/triangle nearest-hit block: configuration registers and
// the front end, triangle queue, back end and divider. Depends on rtn_pkg and those four modules.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | triangle beat, first flag in tuser, last in tlast
//  m_*      | out       | m_tvalid/m_tready  | nearest hit beat, hit flag in tuser
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// A triangle that fails the plane and barycentric tests ends after the check, one that
// loses the distance compare after the distance divide, and an accepted one after the
// normal blends. The shared bit-per-cycle divider makes one pass for the distance and
// one per normal component; one chunked multiplier serves all products.
// Reset clears the hit state to no hit and maximal distance and the configuration registers to zero.
// The front end and the queue take beats while the back end works or the result waits,
// until both fill; a stalled result only holds the back end on a last-of-ray triangle.
module ray_triangle_nearest_hit_top import rtn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// vertex_a, vertex_b, vertex_c, normal_a, normal_b, normal_c, zero pad
	input  logic [IN_TDATA_W-1:0]    s_tdata,
	input  logic                     s_tuser,   // first_of_ray
	input  logic                     s_tlast,   // last_of_ray
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// distance, normal_x, normal_y, normal_z, zero pad
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	output logic                     m_tuser,   // hit
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	logic [2:0][COORD_W-1:0] origin_q;
	logic [2:0][COORD_W-1:0] dir_q;
	logic [DIST_W-1:0]       max_dist_q;

	logic      push_valid;
	logic      push_ready;
	tri_item_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	tri_item_t pop_data;
	div_cmd_t  div_cmd;
	div_rsp_t  div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q   <= '0;
			dir_q      <= '0;
			max_dist_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_q[0] <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: origin_q[1] <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z: origin_q[2] <= cfg_data[COORD_W-1:0];
				REG_DIR_X:    dir_q[0]    <= cfg_data[COORD_W-1:0];
				REG_DIR_Y:    dir_q[1]    <= cfg_data[COORD_W-1:0];
				REG_DIR_Z:    dir_q[2]    <= cfg_data[COORD_W-1:0];
				REG_MAX_DIST: max_dist_q  <= cfg_data[DIST_W-1:0];
				default:      max_dist_q  <= max_dist_q;
			endcase
		end
	end

	rtn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.origin     (origin_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rtn_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rtn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.rsp    (div_rsp)
	);

	rtn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.dir       (dir_q),
		.max_dist  (max_dist_q),
		.div_cmd   (div_cmd),
		.div_rsp   (div_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
